// File: src/assert_macros.svh
// assertion macros shared by the set block
// expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define SSIDL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition that must never hold outside reset
`define SSIDL_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// File: src/ssidl_pkg.sv
// types and constants of the small set block
// no dependencies
package ssidl_pkg;

  localparam int unsigned ValueW     = 32;
  localparam int unsigned OccW       = 5;
  localparam int unsigned QueueDepth = 2;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  typedef enum logic [3:0] {
    OP_INSERT = 4'b0001,
    OP_DELETE = 4'b0010,
    OP_LOOKUP = 4'b0100,
    OP_CLEAR  = 4'b1000
  } op_e;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [ValueW-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic            present;
    logic            refused_full;
    logic            changed;
    logic [OccW-1:0] occupancy;
  } rsp_t;

  typedef struct packed {
    op_e               op;
    logic [ValueW-1:0] value;
  } cmd_t;

endpackage

// File: src/ssidl_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module ssidl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: src/ssidl_front.sv
// front stage: takes requests and classifies them into commands
// depends on ssidl_pkg
module ssidl_front import ssidl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic cmd_valid_o,
  input  logic cmd_ready_i,
  output cmd_t cmd_o
);

  logic vld_q, vld_d;
  cmd_t cmd_q, cmd_d;
  op_e  op;

  always_comb begin
    case (in_req_i.req_type)
      REQ_INSERT: op = OP_INSERT;
      REQ_DELETE: op = OP_DELETE;
      REQ_LOOKUP: op = OP_LOOKUP;
      default:    op = OP_CLEAR;
    endcase
  end

  assign in_ready_o = !vld_q || cmd_ready_i;

  always_comb begin
    vld_d = vld_q;
    cmd_d = cmd_q;
    if (in_valid_i && in_ready_o) begin
      vld_d       = 1'b1;
      cmd_d.op    = op;
      cmd_d.value = in_req_i.item_value;
    end else if (cmd_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

endmodule

// File: src/ssidl_queue.sv
// short command queue between front and back
// depends on ssidl_pkg
module ssidl_queue import ssidl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : PtrW'(wptr_q + 1'b1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : PtrW'(rptr_q + 1'b1);
    end
    if (push && !pop) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

// File: src/ssidl_back.sv
// back end: scans the stored values and carries out each command
// depends on ssidl_pkg and ssidl_ram
module ssidl_back import ssidl_pkg::*; #(
  parameter int unsigned Capacity = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  localparam int unsigned IdxW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW = $clog2(Capacity + 1);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SCAN    = 5'b00010,
    ST_MOVE_RD = 5'b00100,
    ST_MOVE_WR = 5'b01000,
    ST_DONE    = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   rd_idx_q, rd_idx_d;
  logic              rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]   slot_q, slot_d;
  cmd_t              cur_q, cur_d;
  rsp_t              res_q, res_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_q, out_d;

  logic              we, re;
  logic [IdxW-1:0]   waddr, raddr;
  logic [ValueW-1:0] wdata, rdata;
  logic              hit, fin;

  ssidl_ram #(
    .Width (ValueW),
    .Depth (Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign hit = rd_vld_q && (rdata == cur_q.value);
  assign fin = (count_q == '0) || hit ||
               (rd_vld_q && (rd_idx_q == CntW'(count_q - 1'b1)));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    rd_idx_d    = rd_idx_q;
    rd_vld_d    = 1'b0;
    slot_d      = slot_q;
    cur_d       = cur_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = cur_q.value;
    re          = 1'b0;
    raddr       = '0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cur_d = cmd_i;
          idx_d = '0;
          res_d = '{present: 1'b0, refused_full: 1'b0, changed: 1'b0,
                    occupancy: OccW'(count_q)};
          if (cmd_i.op == OP_CLEAR) begin
            count_d             = '0;
            res_d.changed       = 1'b1;
            res_d.occupancy     = '0;
            state_d             = ST_DONE;
          end else if (cmd_i.op == OP_INSERT && count_q >= CntW'(Capacity)) begin
            res_d.refused_full  = 1'b1;
            state_d             = ST_DONE;
          end else begin
            state_d             = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (fin) begin
          res_d.present = hit;
          state_d       = ST_DONE;
          if (cur_q.op == OP_INSERT && !hit) begin
            we              = 1'b1;
            waddr           = count_q[IdxW-1:0];
            count_d         = CntW'(count_q + 1'b1);
            res_d.changed   = 1'b1;
            res_d.occupancy = OccW'(count_d);
          end else if (cur_q.op == OP_DELETE && hit) begin
            count_d         = CntW'(count_q - 1'b1);
            slot_d          = rd_idx_q[IdxW-1:0];
            res_d.changed   = 1'b1;
            res_d.occupancy = OccW'(count_d);
            state_d         = ST_MOVE_RD;
          end
        end else if (idx_q < count_q) begin
          re       = 1'b1;
          raddr    = idx_q[IdxW-1:0];
          rd_vld_d = 1'b1;
          rd_idx_d = idx_q;
          idx_d    = CntW'(idx_q + 1'b1);
        end
      end
      ST_MOVE_RD: begin
        // last entry moves into the freed slot
        re      = 1'b1;
        raddr   = count_q[IdxW-1:0];
        state_d = ST_MOVE_WR;
      end
      ST_MOVE_WR: begin
        we      = 1'b1;
        waddr   = slot_q;
        wdata   = rdata;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    rd_idx_q <= rd_idx_d;
    slot_q   <= slot_d;
    cur_q    <= cur_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// File: src/small_set_insert_delete_lookup.sv
// top level of the small set block: front, command queue and back end
// depends on ssidl_pkg, ssidl_front, ssidl_queue, ssidl_back, assert_macros.svh
//
// Keeps up to CAPACITY distinct 32-bit values. Requests arrive on the in
// channel (in_valid_i / in_ready_o, payload in_req_i) as insert, delete,
// lookup or clear; each gives exactly one response on the out channel
// (out_valid_o / out_ready_i, payload out_rsp_o) with present, refused_full,
// changed and the new occupancy, in request order.
// Each request passes the front register and the queue, then the back end,
// which goes straight from taking a command to its response register for
// clear and a refused insert. The others scan the stored entries one per
// cycle through the single ram read port; a delete that finds its value then
// also moves the last entry into the freed slot. One request is worked on at
// a time and the next is taken as soon as the response is registered; the
// front and queue keep taking up to three further transfers meanwhile.
// Reset empties the set at once (count to zero); no clearing pass is needed.
// When the receiver stalls the response is held in the output register and
// the back end waits after finishing its next request; the queue then fills
// and in_ready_o falls.
`include "assert_macros.svh"

module small_set_insert_delete_lookup import ssidl_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  logic f_valid, f_ready, b_valid, b_ready;
  cmd_t f_cmd, b_cmd;

  ssidl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  ssidl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_cmd_i   (f_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_cmd_o    (b_cmd)
  );

  ssidl_back #(
    .Capacity (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  `SSIDL_NEVER(a_refused_clean, out_valid_o && out_rsp_o.refused_full && (out_rsp_o.present || out_rsp_o.changed), "refused insert reports present or changed")
  `SSIDL_ASSERT(a_refused_full, out_valid_o && out_rsp_o.refused_full |-> out_rsp_o.occupancy == OccW'(CAPACITY), "refused insert while not full")
  `SSIDL_NEVER(a_cmd_while_busy, b_valid && b_ready && out_valid_o && !out_ready_i && $past(b_valid && b_ready), "back end took two commands in a row")

endmodule
